// ----- rtl/ilpg_pkg.sv -----
// Package for the indexed list block: request and status codes, widths,
// and the control struct broadcast to every storage cell.
// No dependencies.
`default_nettype none

package ilpg_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 8;
  localparam int CNT_OUT_W    = 7;
  localparam int REQ_W        = 2;
  localparam int STAT_W       = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Broadcast to all cells in the same cycle. Each cell compares pos with its
  // own place in the row.
  typedef struct packed {
    logic             append_en;
    logic             remove_en;
    logic             rd_load;
    logic             rd_shift;
    logic [IDX_W-1:0] pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/ilpg_cell.sv -----
// One storage cell of the list: holds one entry and one word of the read
// path; a remove or shift copies them from the next cell up. Depends on ilpg_pkg.
`default_nettype none

module ilpg_cell #(
  parameter int POS = 0
) (
  input  wire logic                               clk,
  input  wire ilpg_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [ilpg_pkg::DATA_W-1:0] value,
  input  wire logic signed [ilpg_pkg::DATA_W-1:0] up_data,
  input  wire logic signed [ilpg_pkg::DATA_W-1:0] up_pass,
  output logic signed [ilpg_pkg::DATA_W-1:0]      data,
  output logic signed [ilpg_pkg::DATA_W-1:0]      pass
);

  localparam logic [ilpg_pkg::IDX_W-1:0] MY_POS = ilpg_pkg::IDX_W'(POS);

  always_ff @(posedge clk) begin
    if (ctrl.append_en && ctrl.pos == MY_POS) begin
      data <= value;
    end else if (ctrl.remove_en && MY_POS >= ctrl.pos) begin
      // Every cell at or above the removed place takes its upper neighbor.
      data <= up_data;
    end
  end

  // The read path copies the whole row, then walks it down toward cell 0.
  always_ff @(posedge clk) begin
    if (ctrl.rd_load) begin
      pass <= data;
    end else if (ctrl.rd_shift) begin
      pass <= up_pass;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/indexed_list_push_remove_get.sv -----
// Top level of the indexed list: request decode, count register, read
// sequencer and result register over a row of ilpg_cell. Depends on ilpg_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   request | in        | in_valid / in_stall  | req_type, value, index
//   result  | out       | out_valid / out_stall| status, read_value, count
//
// Append, remove, an out-of-range request and the unused code load the result directly.
// A read in range walks the read path: the row is copied into the read path,
// shifted down one cell a cycle, then cell 0 is loaded into the result register.
// Reset clears the count and control; entry contents are not cleared.
// A request is taken only with no read walking and the result register empty or
// being emptied; a stalled result also holds back the end of a read.
`default_nettype none

module indexed_list_push_remove_get #(
  parameter int CAPACITY = ilpg_pkg::CAPACITY_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [ilpg_pkg::REQ_W-1:0]            req_type,
  input  wire logic signed [ilpg_pkg::DATA_W-1:0]    value,
  input  wire logic [ilpg_pkg::IDX_W-1:0]            index,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [ilpg_pkg::STAT_W-1:0]                status,
  output logic signed [ilpg_pkg::DATA_W-1:0]         read_value,
  output logic [ilpg_pkg::CNT_OUT_W-1:0]             count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ilpg_pkg::IDX_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                          state, state_next;
  logic [CNT_W-1:0]                entry_count, entry_count_next;
  logic [ilpg_pkg::IDX_W-1:0]      walk, walk_next;
  ilpg_pkg::cell_ctrl_t            ctrl;
  logic                            in_acc, out_free, res_load;
  logic [ilpg_pkg::STAT_W-1:0]     res_status;
  logic signed [ilpg_pkg::DATA_W-1:0] res_value;
  logic                            idx_oob, is_full;

  logic signed [ilpg_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic signed [ilpg_pkg::DATA_W-1:0] cell_pass [CAPACITY];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign idx_oob  = CMP_W'(index) >= CMP_W'(entry_count);
  assign is_full  = entry_count == FULL_CNT;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    walk_next        = walk;
    ctrl             = '0;
    res_load         = 1'b0;
    res_status       = ilpg_pkg::ST_OK;
    res_value        = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type)
            ilpg_pkg::REQ_APPEND: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = ilpg_pkg::ST_FULL;
              end else begin
                ctrl.append_en   = 1'b1;
                ctrl.pos         = ilpg_pkg::IDX_W'(entry_count);
                entry_count_next = entry_count + CNT_W'(1);
              end
            end
            ilpg_pkg::REQ_REMOVE: begin
              res_load = 1'b1;
              if (idx_oob) begin
                res_status = ilpg_pkg::ST_OOB;
              end else begin
                ctrl.remove_en   = 1'b1;
                ctrl.pos         = index;
                entry_count_next = entry_count - CNT_W'(1);
              end
            end
            ilpg_pkg::REQ_READ: begin
              if (idx_oob) begin
                res_load   = 1'b1;
                res_status = ilpg_pkg::ST_OOB;
              end else begin
                ctrl.rd_load = 1'b1;
                walk_next    = index;
                state_next   = S_READ;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (walk != '0) begin
          ctrl.rd_shift = 1'b1;
          walk_next     = walk - ilpg_pkg::IDX_W'(1);
        end else if (out_free) begin
          res_load   = 1'b1;
          res_value  = cell_pass[0];
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_top
      ilpg_cell #(.POS(g)) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .value   (value),
        .up_data (cell_data[g]),
        .up_pass (cell_pass[g]),
        .data    (cell_data[g]),
        .pass    (cell_pass[g])
      );
    end else begin : g_mid
      ilpg_cell #(.POS(g)) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .value   (value),
        .up_data (cell_data[g+1]),
        .up_pass (cell_pass[g+1]),
        .data    (cell_data[g]),
        .pass    (cell_pass[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      walk        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      walk        <= walk_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The count reported is the one after this request is applied.
  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= res_status;
      read_value <= res_value;
      count      <= ilpg_pkg::CNT_OUT_W'(entry_count_next);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ilpg_checker.sv -----
// Port-level checker for the indexed list, bound to the top level.
// Depends on ilpg_pkg and indexed_list_push_remove_get.
`default_nettype none

module ilpg_checker #(
  parameter int CAPACITY = ilpg_pkg::CAPACITY_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic [ilpg_pkg::REQ_W-1:0]         req_type,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [ilpg_pkg::STAT_W-1:0]        status,
  input wire logic signed [ilpg_pkg::DATA_W-1:0] read_value,
  input wire logic [ilpg_pkg::CNT_OUT_W-1:0]     count
);

  localparam logic [ilpg_pkg::CNT_OUT_W-1:0] FULL_OUT = ilpg_pkg::CNT_OUT_W'(CAPACITY);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value)
      && $stable(count))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ilpg_pkg::ST_FULL |-> count == FULL_OUT)
    else $error("full status with a count below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ilpg_pkg::ST_OK |-> read_value == '0)
    else $error("rejected request returned a nonzero value");

  // A non-read transfer always yields its result in the next cycle.
  a_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type != ilpg_pkg::REQ_READ |=> out_valid)
    else $error("single-cycle request produced no result");

endmodule

bind indexed_list_push_remove_get ilpg_checker #(.CAPACITY(CAPACITY)) u_ilpg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .req_type   (req_type),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .read_value (read_value),
  .count      (count)
);

`default_nettype wire

// ----- tb/ilpg_result_check.sv -----
// Result checker for the indexed list: keeps its own copy of the list, predicts
// one result per accepted request and compares every result transfer in order.
// Depends on ilpg_pkg.
module ilpg_result_check #(
  parameter int CAPACITY = ilpg_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [ilpg_pkg::REQ_W-1:0]          req_type,
  input  wire logic signed [ilpg_pkg::DATA_W-1:0]  value,
  input  wire logic [ilpg_pkg::IDX_W-1:0]          index,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic [ilpg_pkg::STAT_W-1:0]         status,
  input  wire logic signed [ilpg_pkg::DATA_W-1:0]  read_value,
  input  wire logic [ilpg_pkg::CNT_OUT_W-1:0]      count,
  output int                                       failures,
  output int                                       pending
);

  typedef struct packed {
    logic [ilpg_pkg::STAT_W-1:0]        status;
    logic signed [ilpg_pkg::DATA_W-1:0] read_value;
    logic [ilpg_pkg::CNT_OUT_W-1:0]     count;
  } list_result_t;

  logic signed [ilpg_pkg::DATA_W-1:0] entries [CAPACITY];
  int                                 held;
  int                                 results_seen;
  list_result_t                       expected_results [$];

  initial begin
    failures = 0;
    pending = 0;
    held = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    failures++;
    $display("%0t ilpg result %0d: %s", $time, results_seen, msg);
  endtask

  // Applies one request to the local list and returns the result it produces.
  function automatic list_result_t apply_request(
      input logic [ilpg_pkg::REQ_W-1:0] op,
      input logic signed [ilpg_pkg::DATA_W-1:0] word,
      input logic [ilpg_pkg::IDX_W-1:0] pos);
    list_result_t r;
    int i;
    r = '0;
    r.status = ilpg_pkg::ST_OK;
    case (op)
      ilpg_pkg::REQ_APPEND: begin
        if (held >= CAPACITY) begin
          r.status = ilpg_pkg::ST_FULL;
        end else begin
          entries[held] = word;
          held++;
        end
      end
      ilpg_pkg::REQ_REMOVE: begin
        if (int'(pos) >= held) begin
          r.status = ilpg_pkg::ST_OOB;
        end else begin
          // Later entries slide down one place to close the gap.
          for (i = int'(pos); i + 1 < held; i++) entries[i] = entries[i + 1];
          held--;
        end
      end
      ilpg_pkg::REQ_READ: begin
        if (int'(pos) >= held) r.status = ilpg_pkg::ST_OOB;
        else r.read_value = entries[int'(pos)];
      end
      default: ;
    endcase
    r.count = ilpg_pkg::CNT_OUT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      held = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(req_type, value, index));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status, status));
          if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value expected %0d got %0d",
                                      want.read_value, read_value));
          if (count !== want.count)
            report_mismatch($sformatf("count expected %0d got %0d", want.count, count));
        end
        results_seen++;
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/indexed_list_push_remove_get_tb.sv -----
// Top of the indexed list testbench: clock, reset, request stimulus and result
// back-pressure around the block, with ilpg_result_check doing the checking.
// Depends on ilpg_pkg, indexed_list_push_remove_get and ilpg_result_check.
module indexed_list_push_remove_get_tb;

  localparam int                           CAPACITY    = ilpg_pkg::CAPACITY_DEF;
  localparam logic [ilpg_pkg::REQ_W-1:0]   REQ_UNUSED  = 2'd3;
  localparam int                           RANDOM_REQS = 1230;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [ilpg_pkg::REQ_W-1:0]         req_type = ilpg_pkg::REQ_APPEND;
  logic signed [ilpg_pkg::DATA_W-1:0] value = '0;
  logic [ilpg_pkg::IDX_W-1:0]         index = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [ilpg_pkg::STAT_W-1:0]        status;
  logic signed [ilpg_pkg::DATA_W-1:0] read_value;
  logic [ilpg_pkg::CNT_OUT_W-1:0]     count;
  int                                 failures;
  int                                 pending;

  // Entry count as the stimulus sees it, used only to aim indexes.
  int                                 fill = 0;
  bit                                 send_quiet = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  indexed_list_push_remove_get #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value), .index(index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value), .count(count)
  );

  ilpg_result_check #(.CAPACITY(CAPACITY)) check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value), .index(index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value), .count(count),
    .failures(failures), .pending(pending)
  );

  // Called at a rising edge; returns at the edge where the request transfer happens.
  task automatic offer_request(input logic [ilpg_pkg::REQ_W-1:0] op,
                               input logic signed [ilpg_pkg::DATA_W-1:0] word,
                               input logic [ilpg_pkg::IDX_W-1:0] pos);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type <= op;
    value <= word;
    index <= pos;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == ilpg_pkg::REQ_APPEND && fill < CAPACITY) fill++;
    else if (op == ilpg_pkg::REQ_REMOVE && int'(pos) < fill) fill--;
  endtask

  function automatic logic signed [ilpg_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ilpg_pkg::IDX_W-1:0] pick_index();
    if (fill > 0 && $urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return ilpg_pkg::IDX_W'(fill - 1);
        default: return ilpg_pkg::IDX_W'($urandom_range(0, fill - 1));
      endcase
    end
    return ilpg_pkg::IDX_W'($urandom_range(0, 255));
  endfunction

  // Result side: random stall per result, quiet stretches, and one long hold-off.
  initial begin
    int hold;
    int taken;
    bit quiet_out;
    taken = 0;
    quiet_out = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      hold = quiet_out ? 0 : $urandom_range(0, 14);
      if (taken == 400) hold = 400;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  initial begin
    int n;
    int phase;
    int pick;
    int append_pct;
    int remove_pct;
    logic [ilpg_pkg::REQ_W-1:0] op;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, extreme words, first/middle/last positions, unused code.
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd0);
    offer_request(ilpg_pkg::REQ_REMOVE, '0, 8'd0);
    offer_request(ilpg_pkg::REQ_REMOVE, '0, 8'd255);
    offer_request(REQ_UNUSED, -32'sd1, 8'd255);
    offer_request(ilpg_pkg::REQ_APPEND, 32'sh8000_0000, 8'd255);
    offer_request(ilpg_pkg::REQ_APPEND, 32'sh7fff_ffff, 8'd0);
    offer_request(ilpg_pkg::REQ_APPEND, '0, 8'd0);
    offer_request(ilpg_pkg::REQ_APPEND, -32'sd1, 8'd0);
    offer_request(ilpg_pkg::REQ_APPEND, 32'sh5555_aaaa, 8'd0);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd0);
    offer_request(ilpg_pkg::REQ_READ, -32'sd1, 8'd4);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd5);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd255);
    offer_request(ilpg_pkg::REQ_REMOVE, '0, 8'd2);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd2);
    offer_request(ilpg_pkg::REQ_REMOVE, '0, 8'd3);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd3);
    offer_request(ilpg_pkg::REQ_REMOVE, '0, 8'd0);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd0);
    offer_request(REQ_UNUSED, 32'sh1234_5678, 8'd1);
    offer_request(ilpg_pkg::REQ_READ, '0, 8'd1);
    offer_request(ilpg_pkg::REQ_REMOVE, '0, 8'd2);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random: phases that fill the list to full, hold it mid-way, and drain it.
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_REQS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      phase = (n / 150) % 3;
      append_pct = (phase == 0) ? 75 : (phase == 1) ? 40 : 15;
      remove_pct = (phase == 0) ? 10 : (phase == 1) ? 30 : 60;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = REQ_UNUSED;
      else if (pick < append_pct) op = ilpg_pkg::REQ_APPEND;
      else if (pick < append_pct + remove_pct) op = ilpg_pkg::REQ_REMOVE;
      else op = ilpg_pkg::REQ_READ;
      offer_request(op, pick_word(), pick_index());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("indexed_list_push_remove_get_tb: PASS");
    end else begin
      $display("indexed_list_push_remove_get_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("indexed_list_push_remove_get_tb: FAIL");
    $finish;
  end

endmodule
